FILE: hdl/twdq_pkg.sv
// Shared types, constants and state encoding for the time-window dedup event queue.
`default_nettype none

package twdq_pkg;

  // Default number of entries held by the window store.
  localparam int DEPTH_DEF = 64;

  // Configuration port geometry and register map.
  localparam int          PADDR_W     = 3;
  localparam logic [0:0]  REG_WINDOW  = 1'b0;
  localparam logic [31:0] WINDOW_RESET = 32'd100;

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_DUP    = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT,
    S_TAIL,
    S_HEAD,
    S_EVICT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] event_id;
    logic [31:0] event_time;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [6:0]  evicted_count;
    logic [6:0]  live_count;
    logic [31:0] oldest_time;
    logic [31:0] newest_time;
    logic        window_empty;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic insert;
    logic tail_rd;
    logic head_rd;
    logic evict;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic scan_done;
    logic evict_done;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/time_window_dedup_event_queue_core.sv
// Top level of the time-window dedup event queue: config port, controller and datapath.
//
// Usage: an event word (id and timestamp) is offered on in_data with start.
// It is taken at a rising edge where start is high and busy is low; busy then
// stays high until the result word has been shown. The block first compares
// the id against every live entry, then pushes it at the tail unless it is a
// duplicate or the store is full, and finally pops head entries while the
// head's time is at or below the tail's time minus the window length.
// The duplicate scan reads one stored id per cycle and stops at the first
// match, and eviction pops one head entry per cycle.
// The result word appears on out_data with out_valid high for exactly one
// cycle, in the last cycle of busy; the receiver cannot stall it.
// The window length is written through the APB-style port; the user must
// write it only while busy is low, as the block itself does not enforce this.
// Reset empties the queue (head and count cleared), sets the window length to
// 100 and returns the controller to idle; store contents are not cleared.
`default_nettype none

module time_window_dedup_event_queue_core import twdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_word_t           in_data,
  output logic                    out_valid,
  output out_word_t               out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  logic [31:0] window;
  dp_cmd_t     cmd;
  dp_status_t  st;

  // Window length register.
  twdq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .window  (window)
  );

  // Sequencer: one word at a time through scan, insert, eviction, result.
  twdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Stores and ring arithmetic.
  twdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .window   (window),
    .in_data  (in_data),
    .st       (st),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

FILE: hdl/twdq_cfg.sv
// Configuration register file holding the window length behind an APB-style port.
`default_nettype none

module twdq_cfg import twdq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output logic      [31:0]        window
);

  logic [31:0] window_r;
  logic [31:0] window_nxt;
  logic [0:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    window_nxt = window_r;
    if (wr_en && (reg_idx == REG_WINDOW)) begin
      window_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else begin
      window_r <= window_nxt;
    end
  end

  assign prdata = (reg_idx == REG_WINDOW) ? window_r : '0;
  assign window = window_r;

endmodule

`default_nettype wire

FILE: hdl/twdq_ctrl.sv
// Controller state machine sequencing scan, insert, eviction and result strobe.
`default_nettype none

module twdq_ctrl import twdq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire dp_status_t st,
  output dp_cmd_t         cmd,
  output logic            busy,
  output logic            out_valid
);

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_SCAN;
      S_SCAN:   if (st.scan_done) state_nxt = S_INSERT;
      S_INSERT: state_nxt = S_TAIL;
      S_TAIL:   state_nxt = S_HEAD;
      S_HEAD:   state_nxt = S_EVICT;
      S_EVICT:  if (st.evict_done) state_nxt = S_OUT;
      S_OUT:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_SCAN:   cmd.scan    = 1'b1;
      S_INSERT: cmd.insert  = 1'b1;
      S_TAIL:   cmd.tail_rd = 1'b1;
      S_HEAD:   cmd.head_rd = 1'b1;
      S_EVICT:  cmd.evict   = 1'b1;
      S_OUT:    out_valid   = 1'b1;
      default:  busy        = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/twdq_dp.sv
// Datapath with the id and time stores, ring pointers, scan and eviction logic.
`default_nettype none

module twdq_dp import twdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  input  wire logic [31:0] window,
  input  wire in_word_t    in_data,
  output dp_status_t       st,
  output out_word_t        out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0] id_mem   [DEPTH];
  logic [31:0] time_mem [DEPTH];

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic          dup_r, dup_nxt;
  in_word_t      in_r, in_nxt;
  logic [31:0]   latest_r, latest_nxt;
  logic [31:0]   limit_r, limit_nxt;
  logic          evict_en_r, evict_en_nxt;
  logic [CW-1:0] evicted_r, evicted_nxt;
  status_t       status_r, status_nxt;
  logic [31:0]   oldest_r, oldest_nxt;
  logic [31:0]   newest_r, newest_nxt;
  logic [31:0]   id_rd_r;
  logic [31:0]   time_rd_r;

  logic          scan_issue;
  logic          scan_hit;
  logic          pop;
  logic          full;
  logic          we;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [CW+6:0] count_ext;
  logic [CW+6:0] evicted_ext;

  // Ring position of head plus an offset below DEPTH.
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign scan_issue = scan_idx_r < count_r;
  assign scan_hit   = cmp_vld_r && (id_rd_r == in_r.event_id);
  assign pop        = evict_en_r && (count_r != '0) && (time_rd_r <= limit_r);
  assign full       = count_r == CW'(DEPTH);
  assign we         = cmd.insert && !dup_r && !full;
  assign wr_addr    = wrap_add(head_r, count_r);

  always_comb begin
    rd_addr = head_r;
    if (cmd.scan) begin
      rd_addr = wrap_add(head_r, scan_idx_r);
    end else if (cmd.tail_rd) begin
      rd_addr = wrap_add(head_r, count_r - CW'(1));
    end else if (cmd.evict && pop) begin
      rd_addr = wrap_add(head_r, CW'(1));
    end
  end

  assign st.scan_done  = !scan_issue || scan_hit;
  assign st.evict_done = !pop;

  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    scan_idx_nxt = scan_idx_r;
    cmp_vld_nxt  = cmp_vld_r;
    dup_nxt      = dup_r;
    in_nxt       = in_r;
    latest_nxt   = latest_r;
    limit_nxt    = limit_r;
    evict_en_nxt = evict_en_r;
    evicted_nxt  = evicted_r;
    status_nxt   = status_r;
    oldest_nxt   = oldest_r;
    newest_nxt   = newest_r;

    if (cmd.load) begin
      in_nxt       = in_data;
      scan_idx_nxt = '0;
      cmp_vld_nxt  = 1'b0;
      dup_nxt      = 1'b0;
      evicted_nxt  = '0;
    end

    if (cmd.scan) begin
      if (scan_issue) begin
        scan_idx_nxt = scan_idx_r + CW'(1);
      end
      cmp_vld_nxt = scan_issue && !scan_hit;
      dup_nxt     = dup_r || scan_hit;
    end

    if (cmd.insert) begin
      if (dup_r) begin
        status_nxt = ST_DUP;
      end else if (full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_STORED;
        count_nxt  = count_r + CW'(1);
      end
    end

    if (cmd.head_rd) begin
      latest_nxt   = time_rd_r;
      limit_nxt    = time_rd_r - window;
      evict_en_nxt = window <= time_rd_r;
    end

    if (cmd.evict) begin
      if (pop) begin
        head_nxt    = wrap_add(head_r, CW'(1));
        count_nxt   = count_r - CW'(1);
        evicted_nxt = evicted_r + CW'(1);
      end else begin
        oldest_nxt = (count_r != '0) ? time_rd_r : '0;
        newest_nxt = (count_r != '0) ? latest_r : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    cmp_vld_r  <= cmp_vld_nxt;
    dup_r      <= dup_nxt;
    in_r       <= in_nxt;
    latest_r   <= latest_nxt;
    limit_r    <= limit_nxt;
    evict_en_r <= evict_en_nxt;
    evicted_r  <= evicted_nxt;
    status_r   <= status_nxt;
    oldest_r   <= oldest_nxt;
    newest_r   <= newest_nxt;
  end

  // Store write port.
  always_ff @(posedge clk) begin
    if (we) begin
      id_mem[wr_addr]   <= in_r.event_id;
      time_mem[wr_addr] <= in_r.event_time;
    end
  end

  // Store read port, data registered.
  always_ff @(posedge clk) begin
    id_rd_r   <= id_mem[rd_addr];
    time_rd_r <= time_mem[rd_addr];
  end

  assign count_ext   = (CW+7)'(count_r);
  assign evicted_ext = (CW+7)'(evicted_r);

  assign out_data.status        = status_r;
  assign out_data.evicted_count = evicted_ext[6:0];
  assign out_data.live_count    = count_ext[6:0];
  assign out_data.oldest_time   = oldest_r;
  assign out_data.newest_time   = newest_r;
  assign out_data.window_empty  = count_r == '0;

endmodule

`default_nettype wire

FILE: hdl/twdq_checker.sv
// Port-level checker for the time-window dedup event queue, bound to the top level.
`default_nettype none

module twdq_checker import twdq_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_word_t out_data
);

  // A result word only appears while the block is working on a word.
  a_valid_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside busy");

  // An accepted word makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // The strobe lasts exactly one cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Busy only drops after the result word has been shown.
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> $past(out_valid))
    else $error("busy dropped without a result word");

  // An empty window reports no entries and zero times.
  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.window_empty) |->
      ((out_data.live_count == 7'd0) && (out_data.oldest_time == 32'd0) &&
       (out_data.newest_time == 32'd0)))
    else $error("empty window with nonzero fields");

endmodule

bind time_window_dedup_event_queue_core twdq_checker u_twdq_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the time-window dedup event queue core.

module tb_top;
  import twdq_pkg::*;

  // Store size of the block under test, kept in step with its default.
  localparam int STORE_DEPTH = DEPTH_DEF;

  // Register map: the window length is register 0, and the next slot holds no register.
  localparam logic [PADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

  // The random part stops once about this many event words are queued.
  localparam int EVENT_TARGET = 1100;

  // Idle cycles that the driver waits before a register write. They are counted once
  // nothing is outstanding.
  localparam int SETTLE_CYCLES = 2;

  // Cycles that pass after the last result, so that a stray result is still caught.
  localparam int TAIL_CYCLES = 80;

  // One entry of the driver's queue: an event word or a register write.
  typedef struct {
    bit                 is_cfg;
    logic [PADDR_W-1:0] addr;
    logic [31:0]        data;
    in_word_t           word;
  } pending_op_t;

  typedef enum logic [2:0] {
    DRV_PICK,
    DRV_GAP,
    DRV_HOLD,
    DRV_DRAIN,
    DRV_ACCESS,
    DRV_WRITE
  } drv_state_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  in_word_t           in_data = '0;
  logic               out_valid;
  out_word_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  time_window_dedup_event_queue_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Stimulus waiting to be driven, and the result words predicted for accepted events.
  pending_op_t pending_ops[$];
  out_word_t   window_results_q[$];
  int          mismatches = 0;

  // The testbench's own copy of the window store. The oldest entry sits at
  // win_head, and win_live entries follow it around the ring.
  logic [31:0] win_ids[STORE_DEPTH];
  logic [31:0] win_times[STORE_DEPTH];
  int          win_head = 0;
  int          win_live = 0;
  logic [31:0] win_length = WINDOW_RESET;

  // Generator state: recently issued ids (to make duplicates) and a running count.
  logic [31:0] recent_ids[$];
  int          event_total = 0;

  // Driver state.
  drv_state_t  drv_state = DRV_PICK;
  pending_op_t cur_op;
  int          gap_cnt = 0;
  int          settle_cnt = 0;
  bit          quiet_run = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Safety net: even the slowest correct run finishes far earlier than this.
  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Works out the result word for one event and updates the store copy. The id is
  // searched among the live entries, and the event is pushed unless it is a duplicate or
  // the store is full. Then the head is popped while its time is at or below the tail
  // time minus the window length. The threshold never wraps below zero.
  function automatic out_word_t predict_window_result(in_word_t w);
    out_word_t   r;
    bit          hit;
    int          slot;
    int          evicted;
    logic [31:0] latest;
    logic [31:0] limit;
    hit = 1'b0;
    evicted = 0;
    for (int k = 0; k < win_live; k++) begin
      if (win_ids[(win_head + k) % STORE_DEPTH] == w.event_id) hit = 1'b1;
    end
    if (hit) begin
      r.status = ST_DUP;
    end else if (win_live >= STORE_DEPTH) begin
      r.status = ST_FULL;
    end else begin
      slot = (win_head + win_live) % STORE_DEPTH;
      win_ids[slot] = w.event_id;
      win_times[slot] = w.event_time;
      win_live++;
      r.status = ST_STORED;
    end
    // A duplicate or a dropped event still runs the eviction pass, using the old tail.
    if (win_live > 0) begin
      latest = win_times[(win_head + win_live - 1) % STORE_DEPTH];
      if (win_length <= latest) begin
        limit = latest - win_length;
        // Stop at the first head entry that is newer than the threshold, even when
        // older entries lie behind it.
        while (win_live > 0 && win_times[win_head] <= limit) begin
          win_head = (win_head + 1) % STORE_DEPTH;
          win_live--;
          evicted++;
        end
      end
    end
    r.evicted_count = 7'(evicted);
    r.live_count = 7'(win_live);
    r.oldest_time = (win_live > 0) ? win_times[win_head] : 32'd0;
    r.newest_time = (win_live > 0) ? win_times[(win_head + win_live - 1) % STORE_DEPTH] : 32'd0;
    r.window_empty = (win_live == 0);
    return r;
  endfunction

  task automatic check_result(out_word_t want, out_word_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.evicted_count !== want.evicted_count) begin
      $error("evicted_count: expected %0d, got %0d", want.evicted_count, got.evicted_count);
      mismatches++;
    end
    if (got.live_count !== want.live_count) begin
      $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
      mismatches++;
    end
    if (got.oldest_time !== want.oldest_time) begin
      $error("oldest_time: expected %h, got %h", want.oldest_time, got.oldest_time);
      mismatches++;
    end
    if (got.newest_time !== want.newest_time) begin
      $error("newest_time: expected %h, got %h", want.newest_time, got.newest_time);
      mismatches++;
    end
    if (got.window_empty !== want.window_empty) begin
      $error("window_empty: expected %0d, got %0d", want.window_empty, got.window_empty);
      mismatches++;
    end
  endtask

  // Before each word the sender waits a random gap. Now and then it switches into a
  // stretch with no waits at all, and later switches back out of it.
  function automatic int draw_gap();
    if ($urandom_range(0, 31) == 0) quiet_run = !quiet_run;
    return quiet_run ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic add_event(logic [31:0] id, logic [31:0] t);
    pending_op_t op;
    op.is_cfg = 1'b0;
    op.addr = '0;
    op.data = '0;
    op.word.event_id = id;
    op.word.event_time = t;
    pending_ops.push_back(op);
    recent_ids.push_back(id);
    if (recent_ids.size() > STORE_DEPTH) void'(recent_ids.pop_front());
    event_total++;
  endtask

  task automatic add_cfg(logic [PADDR_W-1:0] addr, logic [31:0] data);
    pending_op_t op;
    op.is_cfg = 1'b1;
    op.addr = addr;
    op.data = data;
    op.word = '0;
    pending_ops.push_back(op);
  endtask

  // Chooses an id that was issued recently (a likely duplicate) with odds 1 in n.
  // Otherwise it chooses a fresh random id.
  function automatic logic [31:0] pick_id(int n);
    if (recent_ids.size() != 0 && $urandom_range(0, n - 1) == 0)
      return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    return $urandom;
  endfunction

  // Driver. It takes operations from pending_ops in order. An event word is offered with
  // start after its gap, and it is taken at an edge where busy is low. When the next word
  // needs no gap, start simply stays high and only the payload changes. A register write
  // first waits until no result is outstanding and the block is idle. Then it runs the
  // setup and access cycles of the APB transfer.
  always @(posedge clk) begin : drive
    pending_op_t op;
    int          gap;
    if (!rst_n) begin
      start <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      drv_state <= DRV_PICK;
    end else begin
      case (drv_state)
        DRV_PICK: begin
          if (pending_ops.size() != 0) begin
            op = pending_ops.pop_front();
            cur_op <= op;
            if (op.is_cfg) begin
              settle_cnt <= 0;
              drv_state <= DRV_DRAIN;
            end else begin
              gap = draw_gap();
              in_data <= op.word;
              if (gap == 0) begin
                start <= 1'b1;
                drv_state <= DRV_HOLD;
              end else begin
                gap_cnt <= gap - 1;
                drv_state <= DRV_GAP;
              end
            end
          end
        end
        DRV_GAP: begin
          if (gap_cnt == 0) begin
            start <= 1'b1;
            drv_state <= DRV_HOLD;
          end else begin
            gap_cnt <= gap_cnt - 1;
          end
        end
        DRV_HOLD: begin
          if (!busy) begin
            // The word on in_data is taken at this edge.
            if (pending_ops.size() != 0 && !pending_ops[0].is_cfg) begin
              op = pending_ops.pop_front();
              gap = draw_gap();
              in_data <= op.word;
              if (gap != 0) begin
                start <= 1'b0;
                gap_cnt <= gap - 1;
                drv_state <= DRV_GAP;
              end
            end else begin
              start <= 1'b0;
              drv_state <= DRV_PICK;
            end
          end
        end
        DRV_DRAIN: begin
          if (window_results_q.size() == 0 && !busy) begin
            if (settle_cnt >= SETTLE_CYCLES) begin
              psel <= 1'b1;
              pwrite <= 1'b1;
              paddr <= cur_op.addr;
              pwdata <= cur_op.data;
              drv_state <= DRV_ACCESS;
            end else begin
              settle_cnt <= settle_cnt + 1;
            end
          end else begin
            settle_cnt <= 0;
          end
        end
        DRV_ACCESS: begin
          penable <= 1'b1;
          drv_state <= DRV_WRITE;
        end
        default: begin
          // The register takes the write at this edge, since pready is always high.
          psel <= 1'b0;
          penable <= 1'b0;
          pwrite <= 1'b0;
          drv_state <= DRV_PICK;
        end
      endcase
    end
  end

  // Monitor. It follows register writes into the predictor, predicts a result word for
  // every accepted event word and checks each result word against the oldest prediction.
  // All inputs are driven with nonblocking assignments, so it sees settled values here.
  always @(posedge clk) begin
    if (rst_n) begin
      if (psel && penable && pwrite && pready && paddr == WINDOW_ADDR) win_length = pwdata;
      if (start && !busy) window_results_q.push_back(predict_window_result(in_data));
      if (out_valid === 1'b1) begin
        if (window_results_q.size() == 0) begin
          $error("result word with no event outstanding: %p", out_data);
          mismatches++;
        end else begin
          check_result(window_results_q.pop_front(), out_data);
        end
      end
    end
  end

  initial begin : stimulus
    int          kind;
    int          n;
    logic [31:0] t;
    logic [31:0] w;

    // Directed part. The window starts at its reset value of 100.
    add_event(32'h0, 32'h0);                   // first entry, window wider than latest
    add_event(32'h0, 32'h5);                   // duplicate id
    add_event(32'h1, 32'd100);                 // time equal to the threshold is evicted
    add_event(32'h2, 32'd50);                  // out-of-order, older than the tail
    add_event(32'h3, 32'd250);                 // evicts two entries
    add_event(32'h4, 32'd300);
    add_event(32'h5, 32'd10);                  // old entry hidden behind newer ones
    add_event(32'h6, 32'd360);                 // eviction stops at a newer head
    add_event(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // extreme id and time
    add_event(32'hFFFF_FFFF, 32'h0);           // duplicate, eviction on the old tail
    // A zero window evicts everything at or below the tail, the tail included.
    add_cfg(WINDOW_ADDR, 32'h0);
    add_event(32'h7, 32'h5);
    add_event(32'h8, 32'hFFFF_FFFF);
    add_event(32'h8, 32'h3);
    // Widest window: no eviction unless the tail time is all ones.
    add_cfg(WINDOW_ADDR, 32'hFFFF_FFFF);
    add_event(32'h9, 32'h0);
    add_event(32'hA, 32'hFFFF_FFFE);
    add_event(32'hB, 32'hFFFF_FFFF);
    // A write to the unmapped slot must leave the window length alone.
    add_cfg(UNMAPPED_ADDR, 32'h0);
    add_event(32'hC, 32'h1);
    add_event(32'hAAAA_AAAA, 32'h5555_5555);
    add_cfg(WINDOW_ADDR, 32'h1);
    add_event(32'h5555_5555, 32'h2);
    add_event(32'hD, 32'h3);
    add_event(32'hD, 32'h3);

    // Random part: phases that each start with a register write.
    while (event_total < EVENT_TARGET) begin
      kind = $urandom_range(0, 7);
      case (kind)
        0, 1: begin
          // Fill the store past full, then mix duplicates with drops.
          add_cfg(WINDOW_ADDR, ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : {1'b1, 31'($urandom)});
          t = $urandom_range(0, 1 << 20);
          n = $urandom_range(66, 80);
          repeat (n) begin
            t = t + $urandom_range(0, 3);
            add_event(pick_id(6), t);
          end
        end
        2, 3, 4: begin
          // Sliding window with mostly rising times and frequent duplicates.
          w = $urandom_range(1, 300);
          add_cfg(WINDOW_ADDR, w);
          t = $urandom;
          n = $urandom_range(40, 90);
          repeat (n) begin
            if ($urandom_range(0, 9) == 0) t = t - $urandom_range(0, w);
            else t = t + $urandom_range(0, w / 8 + 1);
            add_event(pick_id(3), t);
          end
        end
        5: begin
          // Noise: any id, any time, any window.
          add_cfg(WINDOW_ADDR, $urandom);
          n = $urandom_range(20, 40);
          repeat (n) add_event(pick_id(8), $urandom);
        end
        6: begin
          // Zero or unit window, which keeps the store nearly empty.
          add_cfg(WINDOW_ADDR, $urandom_range(0, 1));
          t = $urandom_range(0, 1000);
          n = $urandom_range(15, 30);
          repeat (n) begin
            if ($urandom_range(0, 3) == 0) t = t - $urandom_range(0, 3);
            else t = t + $urandom_range(0, 2);
            add_event(pick_id(3), t);
          end
        end
        default: begin
          // Times that cross the wrap from all ones back to zero.
          add_cfg(WINDOW_ADDR, $urandom_range(50, 500));
          t = 32'hFFFF_FFFF - $urandom_range(0, 400);
          n = $urandom_range(30, 60);
          repeat (n) begin
            t = t + $urandom_range(0, 20);
            add_event(pick_id(4), t);
          end
        end
      endcase
    end

    // Wait until every operation has been driven and every result word has come back.
    @(posedge rst_n);
    while (pending_ops.size() != 0 || drv_state != DRV_PICK || start
           || window_results_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
